// ----- rtl/core/lisd_pkg.sv -----
// ----------------------------------------------------------------------------
// lisd_pkg
// Shared types and constants of the laminar interval subset core: default
// sizes, sequencer states, datapath micro-operations and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lisd_pkg;

  // default sizes
  localparam int MAX_SEGS_DEF   = 64;
  localparam int COORD_BITS_DEF = 20;

  // result count width on the output channel
  localparam int BEST_BITS = 7;

  // bundle field widths, wide enough for the largest supported batch
  localparam int IDX_W  = 11;
  localparam int RANK_W = 12;

  // datapath micro-operations, executed in the cycle after issue
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD_EA,
    OP_CMP_DUP,
    OP_FIN_DUP,
    OP_CMP_RANK,
    OP_FIN_RANK,
    OP_ROW_INIT,
    OP_COPY,
    OP_SEL_CLR,
    OP_SEL,
    OP_SEL_TAKE,
    OP_LOAD_D,
    OP_PASS_A,
    OP_PASS_B,
    OP_SUF,
    OP_WB,
    OP_RES
  } op_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DUP_LOAD,
    ST_DUP_CMP,
    ST_DUP_FIN,
    ST_RK_LOAD,
    ST_RK_CMP,
    ST_RK_FIN,
    ST_ROW_INIT,
    ST_COPY,
    ST_SEL_CLR,
    ST_SEL_SCAN,
    ST_SEL_WAIT,
    ST_SEL_CHK,
    ST_SEG_D,
    ST_PASS_A,
    ST_PASS_B,
    ST_SUF,
    ST_WB,
    ST_RES,
    ST_END
  } state_t;

  // command from controller to datapath
  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  idx;
    logic [RANK_W-1:0] row;
    logic [RANK_W-1:0] col;
    logic              zero;
    logic              en;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [IDX_W-1:0]  seg_n;
    logic [RANK_W-1:0] m;
    logic              found;
    logic [RANK_W-1:0] sel_l;
    logic              res_busy;
  } stat_t;

endpackage

// ----- rtl/core/lisd_seg_if.sv -----
// ----------------------------------------------------------------------------
// lisd_seg_if
// Segment input channel: valid/ready handshake with one closed segment and
// the end-of-batch mark.
// ----------------------------------------------------------------------------
interface lisd_seg_if #(
  parameter int COORD_BITS = lisd_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] seg_left;
  logic [COORD_BITS-1:0] seg_right;
  logic                  last;

  modport source (output valid, output seg_left, output seg_right, output last, input ready);
  modport sink (input valid, input seg_left, input seg_right, input last, output ready);
endinterface

// ----- rtl/core/lisd_res_if.sv -----
// ----------------------------------------------------------------------------
// lisd_res_if
// Result channel: valid/ready handshake with the best subset size and the
// overflow mark of one batch.
// ----------------------------------------------------------------------------
interface lisd_res_if;
  logic                           valid;
  logic                           ready;
  logic [lisd_pkg::BEST_BITS-1:0] best_count;
  logic                           overflow;

  modport source (output valid, output best_count, output overflow, input ready);
  modport sink (input valid, input best_count, input overflow, output ready);
endinterface

// ----- rtl/core/laminar_interval_subset_dp_core.sv -----
// ----------------------------------------------------------------------------
// laminar_interval_subset_dp_core
// Largest subset of a batch of closed segments in which every pair is
// disjoint or nested.
// ----------------------------------------------------------------------------
// Segments are taken one per cycle while the core is idle; the one marked
// last closes the batch and starts the evaluation, during which no segment
// is taken. With n held segments (up to MAX_SEGS; extras are dropped and
// flagged) and m = distinct endpoints + 2, a batch runs duplicate marking
// and endpoint ranking, then the row-by-row interval table work. The run
// time is set by
// the single read port of the endpoint store, walked once per endpoint, and
// by the working-row and table memories, one column of a row per cycle in
// each pass. The result sits in an output register; the next batch can
// be loaded while it waits to be taken.
// ----------------------------------------------------------------------------
module laminar_interval_subset_dp_core #(
  parameter int MAX_SEGS   = lisd_pkg::MAX_SEGS_DEF,
  parameter int COORD_BITS = lisd_pkg::COORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  lisd_seg_if.sink     seg_in,
  lisd_res_if.source   res_out
);

  lisd_pkg::cmd_t  cmd;
  lisd_pkg::stat_t stat;
  logic            in_ready;
  logic            in_fire;

  // segment transfer
  assign seg_in.ready = in_ready;
  assign in_fire      = seg_in.valid && in_ready;

  lisd_ctrl #(.MAX_SEGS(MAX_SEGS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_last  (seg_in.last),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lisd_dp #(.MAX_SEGS(MAX_SEGS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_fire   (in_fire),
    .in_left   (seg_in.seg_left),
    .in_right  (seg_in.seg_right),
    .res_ready (res_out.ready),
    .res_valid (res_out.valid),
    .res_count (res_out.best_count),
    .res_ovf   (res_out.overflow)
  );

endmodule

// ----- rtl/core/lisd_ram.sv -----
// ----------------------------------------------------------------------------
// lisd_ram
// Generic single-write, single-read RAM with registered read data. A read of
// the address being written returns the new data.
// ----------------------------------------------------------------------------
module lisd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read with write bypass
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/lisd_ctrl.sv -----
// ----------------------------------------------------------------------------
// lisd_ctrl
// Sequencer of the core: takes segments while idle, then steps through
// duplicate marking, endpoint ranking and the row-by-row interval table
// update, issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module lisd_ctrl #(
  parameter int MAX_SEGS = lisd_pkg::MAX_SEGS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  logic            in_last,
  output logic            in_ready,
  input  lisd_pkg::stat_t stat,
  output lisd_pkg::cmd_t  cmd
);

  localparam int RANKS = 2 * MAX_SEGS + 2;
  localparam int CB    = $clog2(MAX_SEGS + 1);
  localparam int SB    = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
  localparam int EB    = $clog2(2 * MAX_SEGS);
  localparam int RB    = $clog2(RANKS + 1);

  lisd_pkg::state_t st, st_next;
  logic [EB-1:0]    a, a_next;
  logic [EB-1:0]    b, b_next;
  logic [SB-1:0]    s, s_next;
  logic [RB-1:0]    i, i_next;
  logic [RB-1:0]    k, k_next;
  logic [RB-1:0]    j, j_next;

  logic [CB-1:0]    n;
  logic [EB-1:0]    ep_last;
  logic [SB-1:0]    s_last;
  logic [RB-1:0]    m;
  logic [RB-1:0]    mm1;

  // loop bounds from the batch size and the number of distinct endpoints
  assign n       = stat.seg_n[CB-1:0];
  assign ep_last = EB'({n, 1'b0} - (CB + 1)'(1));
  assign s_last  = SB'(n - CB'(1));
  assign m       = stat.m[RB-1:0];
  assign mm1     = m - RB'(1);

  // state and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= lisd_pkg::ST_IDLE;
      a  <= '0;
      b  <= '0;
      s  <= '0;
      i  <= '0;
      k  <= '0;
      j  <= '0;
    end else begin
      st <= st_next;
      a  <= a_next;
      b  <= b_next;
      s  <= s_next;
      i  <= i_next;
      k  <= k_next;
      j  <= j_next;
    end
  end

  // next state and command
  always_comb begin
    st_next  = st;
    a_next   = a;
    b_next   = b;
    s_next   = s;
    i_next   = i;
    k_next   = k;
    j_next   = j;
    in_ready = 1'b0;
    cmd      = '0;
    cmd.op   = lisd_pkg::OP_NOP;

    unique case (st)
      lisd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire && in_last) begin
          a_next  = '0;
          st_next = lisd_pkg::ST_DUP_LOAD;
        end
      end

      // mark first occurrences of each endpoint value
      lisd_pkg::ST_DUP_LOAD: begin
        cmd.op  = lisd_pkg::OP_LOAD_EA;
        cmd.idx = lisd_pkg::IDX_W'(a);
        b_next  = '0;
        st_next = (a == '0) ? lisd_pkg::ST_DUP_FIN : lisd_pkg::ST_DUP_CMP;
      end
      lisd_pkg::ST_DUP_CMP: begin
        cmd.op  = lisd_pkg::OP_CMP_DUP;
        cmd.idx = lisd_pkg::IDX_W'(b);
        b_next  = b + EB'(1);
        if (b == a - EB'(1)) begin
          st_next = lisd_pkg::ST_DUP_FIN;
        end
      end
      lisd_pkg::ST_DUP_FIN: begin
        cmd.op  = lisd_pkg::OP_FIN_DUP;
        cmd.idx = lisd_pkg::IDX_W'(a);
        if (a == ep_last) begin
          a_next  = '0;
          st_next = lisd_pkg::ST_RK_LOAD;
        end else begin
          a_next  = a + EB'(1);
          st_next = lisd_pkg::ST_DUP_LOAD;
        end
      end

      // rank of each endpoint: distinct values below it, plus one
      lisd_pkg::ST_RK_LOAD: begin
        cmd.op  = lisd_pkg::OP_LOAD_EA;
        cmd.idx = lisd_pkg::IDX_W'(a);
        b_next  = '0;
        st_next = lisd_pkg::ST_RK_CMP;
      end
      lisd_pkg::ST_RK_CMP: begin
        cmd.op  = lisd_pkg::OP_CMP_RANK;
        cmd.idx = lisd_pkg::IDX_W'(b);
        b_next  = b + EB'(1);
        if (b == ep_last) begin
          st_next = lisd_pkg::ST_RK_FIN;
        end
      end
      lisd_pkg::ST_RK_FIN: begin
        cmd.op  = lisd_pkg::OP_FIN_RANK;
        cmd.idx = lisd_pkg::IDX_W'(a);
        if (a == ep_last) begin
          i_next  = RB'(1);
          st_next = lisd_pkg::ST_ROW_INIT;
        end else begin
          a_next  = a + EB'(1);
          st_next = lisd_pkg::ST_RK_LOAD;
        end
      end

      // row start: bring the previous row into the working row
      lisd_pkg::ST_ROW_INIT: begin
        cmd.op  = lisd_pkg::OP_ROW_INIT;
        k_next  = RB'(1);
        st_next = lisd_pkg::ST_COPY;
      end
      lisd_pkg::ST_COPY: begin
        cmd.op   = lisd_pkg::OP_COPY;
        cmd.row  = lisd_pkg::RANK_W'(i - RB'(1));
        cmd.col  = lisd_pkg::RANK_W'(k);
        cmd.zero = (i == RB'(1));
        k_next   = k + RB'(1);
        if (k == mm1) begin
          st_next = lisd_pkg::ST_SEL_CLR;
        end
      end

      // pick the next segment ending at this rank, highest left rank first
      lisd_pkg::ST_SEL_CLR: begin
        cmd.op  = lisd_pkg::OP_SEL_CLR;
        s_next  = '0;
        st_next = lisd_pkg::ST_SEL_SCAN;
      end
      lisd_pkg::ST_SEL_SCAN: begin
        cmd.op  = lisd_pkg::OP_SEL;
        cmd.idx = lisd_pkg::IDX_W'(s);
        cmd.row = lisd_pkg::RANK_W'(i);
        s_next  = s + SB'(1);
        if (s == s_last) begin
          st_next = lisd_pkg::ST_SEL_WAIT;
        end
      end
      lisd_pkg::ST_SEL_WAIT: begin
        st_next = lisd_pkg::ST_SEL_CHK;
      end
      lisd_pkg::ST_SEL_CHK: begin
        if (stat.found) begin
          cmd.op  = lisd_pkg::OP_SEL_TAKE;
          j_next  = stat.sel_l[RB-1:0];
          st_next = lisd_pkg::ST_SEG_D;
        end else begin
          k_next  = i + RB'(1);
          st_next = lisd_pkg::ST_SUF;
        end
      end

      // segment update: candidate pass then shifted maximum pass
      lisd_pkg::ST_SEG_D: begin
        cmd.op  = lisd_pkg::OP_LOAD_D;
        cmd.col = lisd_pkg::RANK_W'(j);
        k_next  = RB'(1);
        st_next = lisd_pkg::ST_PASS_A;
      end
      lisd_pkg::ST_PASS_A: begin
        cmd.op   = lisd_pkg::OP_PASS_A;
        cmd.row  = lisd_pkg::RANK_W'(j - RB'(1));
        cmd.col  = lisd_pkg::RANK_W'(k);
        cmd.zero = (j == RB'(1));
        cmd.en   = (k <= j);
        k_next   = k + RB'(1);
        if (k == mm1) begin
          k_next  = RB'(1);
          st_next = lisd_pkg::ST_PASS_B;
        end
      end
      lisd_pkg::ST_PASS_B: begin
        cmd.op   = lisd_pkg::OP_PASS_B;
        cmd.col  = lisd_pkg::RANK_W'(k);
        cmd.zero = (k == mm1);
        k_next   = k + RB'(1);
        if (k == mm1) begin
          st_next = lisd_pkg::ST_SEL_CLR;
        end
      end

      // suffix maximum from the column after the row rank down to one
      lisd_pkg::ST_SUF: begin
        cmd.op   = lisd_pkg::OP_SUF;
        cmd.col  = lisd_pkg::RANK_W'(k);
        cmd.zero = (k == m);
        cmd.en   = (k != i + RB'(1));
        k_next   = k - RB'(1);
        if (k == RB'(1)) begin
          k_next  = RB'(1);
          st_next = lisd_pkg::ST_WB;
        end
      end

      // store the finished row
      lisd_pkg::ST_WB: begin
        cmd.op  = lisd_pkg::OP_WB;
        cmd.row = lisd_pkg::RANK_W'(i);
        cmd.col = lisd_pkg::RANK_W'(k);
        k_next  = k + RB'(1);
        if (k == mm1) begin
          if (i == mm1) begin
            st_next = lisd_pkg::ST_RES;
          end else begin
            i_next  = i + RB'(1);
            st_next = lisd_pkg::ST_ROW_INIT;
          end
        end
      end

      // hand over the result once the output register is free
      lisd_pkg::ST_RES: begin
        if (!stat.res_busy) begin
          cmd.op  = lisd_pkg::OP_RES;
          cmd.col = lisd_pkg::RANK_W'(1);
          st_next = lisd_pkg::ST_END;
        end
      end
      lisd_pkg::ST_END: begin
        st_next = lisd_pkg::ST_IDLE;
      end
      default: begin
        st_next = lisd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/lisd_dp.sv -----
// ----------------------------------------------------------------------------
// lisd_dp
// Datapath of the core: segment, rank, working-row and table memories, the
// compare and maximum logic, and the output register. Each command acts in
// the cycle after it is issued, when its read data is back.
// ----------------------------------------------------------------------------
module lisd_dp #(
  parameter int MAX_SEGS   = lisd_pkg::MAX_SEGS_DEF,
  parameter int COORD_BITS = lisd_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lisd_pkg::cmd_t                 cmd,
  output lisd_pkg::stat_t                stat,
  input  logic                           in_fire,
  input  logic [COORD_BITS-1:0]          in_left,
  input  logic [COORD_BITS-1:0]          in_right,
  input  logic                           res_ready,
  output logic                           res_valid,
  output logic [lisd_pkg::BEST_BITS-1:0] res_count,
  output logic                           res_ovf
);

  localparam int RANKS = 2 * MAX_SEGS + 2;
  localparam int CB    = $clog2(MAX_SEGS + 1);
  localparam int SB    = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
  localparam int EB    = $clog2(2 * MAX_SEGS);
  localparam int RB    = $clog2(RANKS + 1);
  localparam int RA    = $clog2(RANKS);
  localparam int DA    = $clog2(RANKS * RANKS);
  localparam int KW    = RB + SB;
  localparam int BW    = lisd_pkg::BEST_BITS;

  lisd_pkg::cmd_t        cmd_q;

  logic [CB-1:0]         seg_count;
  logic                  ovf;
  logic [RB-1:0]         nd;
  logic [COORD_BITS-1:0] ea;
  logic                  dup;
  logic [RB-1:0]         acc;
  logic [CB-1:0]         d;
  logic [CB-1:0]         run;
  logic                  found;
  logic [KW-1:0]         best_key;
  logic                  prev_valid;
  logic [KW-1:0]         prev_key;

  // memory ports
  logic                  seg_we;
  logic [SB-1:0]         seg_waddr, seg_raddr;
  logic [COORD_BITS-1:0] seg_l_wd, seg_r_wd, seg_l_rd, seg_r_rd;
  logic                  flag_we, flag_wd, flag_rd;
  logic                  rk_l_we, rk_r_we;
  logic [SB-1:0]         rk_waddr;
  logic [RB-1:0]         rk_wd, rk_l_rd, rk_r_rd;
  logic                  cur_we;
  logic [RA-1:0]         cur_waddr, cur_raddr;
  logic [CB-1:0]         cur_wd, cur_rd;
  logic                  scr_we;
  logic [CB-1:0]         scr_wd, scr_rd;
  logic                  dp_we;
  logic [DA-1:0]         dp_waddr, dp_raddr;
  logic [CB-1:0]         dp_rd;

  // consume-stage values
  logic [EB-1:0]         ep_q;
  logic [COORD_BITS-1:0] ev;
  logic [KW-1:0]         key;
  logic [CB-1:0]         dv;
  logic [CB:0]           c_sum;
  logic [CB-1:0]         nxt;
  logic [CB-1:0]         sv;
  logic [CB-1:0]         sr;

  // segment load, smaller endpoint on the left
  assign seg_we    = in_fire && (seg_count < CB'(MAX_SEGS));
  assign seg_waddr = SB'(seg_count);
  assign seg_l_wd  = (in_left > in_right) ? in_right : in_left;
  assign seg_r_wd  = (in_left > in_right) ? in_left : in_right;
  assign seg_raddr = SB'(cmd.idx[EB-1:0] >> 1);

  lisd_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_SEGS)) u_seg_l (
    .clk(clk), .we(seg_we), .waddr(seg_waddr), .wdata(seg_l_wd),
    .raddr(seg_raddr), .rdata(seg_l_rd)
  );
  lisd_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_SEGS)) u_seg_r (
    .clk(clk), .we(seg_we), .waddr(seg_waddr), .wdata(seg_r_wd),
    .raddr(seg_raddr), .rdata(seg_r_rd)
  );

  // first-occurrence flags per endpoint
  assign ep_q    = cmd_q.idx[EB-1:0];
  assign flag_we = (cmd_q.op == lisd_pkg::OP_FIN_DUP);
  assign flag_wd = !dup;

  lisd_ram #(.WIDTH(1), .DEPTH(2 * MAX_SEGS)) u_flag (
    .clk(clk), .we(flag_we), .waddr(ep_q), .wdata(flag_wd),
    .raddr(cmd.idx[EB-1:0]), .rdata(flag_rd)
  );

  // left and right ranks per segment
  assign rk_l_we  = (cmd_q.op == lisd_pkg::OP_FIN_RANK) && !ep_q[0];
  assign rk_r_we  = (cmd_q.op == lisd_pkg::OP_FIN_RANK) && ep_q[0];
  assign rk_waddr = SB'(ep_q >> 1);
  assign rk_wd    = acc + RB'(1);

  lisd_ram #(.WIDTH(RB), .DEPTH(MAX_SEGS)) u_rk_l (
    .clk(clk), .we(rk_l_we), .waddr(rk_waddr), .wdata(rk_wd),
    .raddr(cmd.idx[SB-1:0]), .rdata(rk_l_rd)
  );
  lisd_ram #(.WIDTH(RB), .DEPTH(MAX_SEGS)) u_rk_r (
    .clk(clk), .we(rk_r_we), .waddr(rk_waddr), .wdata(rk_wd),
    .raddr(cmd.idx[SB-1:0]), .rdata(rk_r_rd)
  );

  // working row: read one column ahead in the shifted maximum pass; the
  // column past the row end only matters to the shift and suffix passes
  always_comb begin
    if (cmd.zero && ((cmd.op == lisd_pkg::OP_PASS_B) || (cmd.op == lisd_pkg::OP_SUF))) begin
      cur_raddr = '0;
    end else if (cmd.op == lisd_pkg::OP_PASS_B) begin
      cur_raddr = RA'(cmd.col + lisd_pkg::RANK_W'(1));
    end else begin
      cur_raddr = cmd.col[RA-1:0];
    end
  end

  assign cur_waddr = cmd_q.col[RA-1:0];

  lisd_ram #(.WIDTH(CB), .DEPTH(RANKS)) u_cur (
    .clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wd),
    .raddr(cur_raddr), .rdata(cur_rd)
  );

  lisd_ram #(.WIDTH(CB), .DEPTH(RANKS)) u_scr (
    .clk(clk), .we(scr_we), .waddr(cmd_q.col[RA-1:0]), .wdata(scr_wd),
    .raddr(cmd.col[RA-1:0]), .rdata(scr_rd)
  );

  // table addressed by row * ranks + column; row zero reads as empty
  assign dp_raddr = cmd.zero ? '0
                  : DA'(cmd.row[RA-1:0]) * DA'(RANKS) + DA'(cmd.col[RA-1:0]);
  assign dp_waddr = DA'(cmd_q.row[RA-1:0]) * DA'(RANKS) + DA'(cmd_q.col[RA-1:0]);
  assign dp_we    = (cmd_q.op == lisd_pkg::OP_WB);

  lisd_ram #(.WIDTH(CB), .DEPTH(RANKS * RANKS)) u_tab (
    .clk(clk), .we(dp_we), .waddr(dp_waddr), .wdata(cur_rd),
    .raddr(dp_raddr), .rdata(dp_rd)
  );

  // consume-stage arithmetic
  assign ev    = ep_q[0] ? seg_r_rd : seg_l_rd;
  assign key   = {rk_l_rd, ~cmd_q.idx[SB-1:0]};
  assign dv    = cmd_q.zero ? '0 : dp_rd;
  assign c_sum = (CB + 1)'(d) + (CB + 1)'(dv) + (CB + 1)'(1);
  assign nxt   = cmd_q.zero ? '0 : cur_rd;
  assign sv    = cmd_q.zero ? '0 : cur_rd;
  assign sr    = (cmd_q.en && (run > sv)) ? run : sv;

  assign scr_we = (cmd_q.op == lisd_pkg::OP_PASS_A);
  assign scr_wd = (cmd_q.en && (c_sum > (CB + 1)'(cur_rd))) ? CB'(c_sum) : cur_rd;

  // working row write mux
  always_comb begin
    cur_we = 1'b0;
    cur_wd = cur_rd;
    unique case (cmd_q.op)
      lisd_pkg::OP_COPY: begin
        cur_we = 1'b1;
        cur_wd = dv;
      end
      lisd_pkg::OP_PASS_B: begin
        cur_we = 1'b1;
        cur_wd = (scr_rd > nxt) ? scr_rd : nxt;
      end
      lisd_pkg::OP_SUF: begin
        cur_we = cmd_q.en;
        cur_wd = sr;
      end
      default: begin
        cur_we = 1'b0;
      end
    endcase
  end

  // command pipeline and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q      <= '0;
      seg_count  <= '0;
      ovf        <= 1'b0;
      nd         <= '0;
      found      <= 1'b0;
      prev_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      cmd_q <= cmd;

      if (in_fire) begin
        if (seg_count < CB'(MAX_SEGS)) begin
          seg_count <= seg_count + CB'(1);
        end else begin
          ovf <= 1'b1;
        end
      end

      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end

      unique case (cmd_q.op)
        lisd_pkg::OP_FIN_DUP: begin
          if (!dup) begin
            nd <= nd + RB'(1);
          end
        end
        lisd_pkg::OP_ROW_INIT: begin
          prev_valid <= 1'b0;
        end
        lisd_pkg::OP_SEL_CLR: begin
          found <= 1'b0;
        end
        lisd_pkg::OP_SEL: begin
          if ((rk_r_rd == cmd_q.row[RB-1:0]) && (!prev_valid || (key < prev_key)) &&
              (!found || (key > best_key))) begin
            found <= 1'b1;
          end
        end
        lisd_pkg::OP_SEL_TAKE: begin
          prev_valid <= 1'b1;
        end
        lisd_pkg::OP_RES: begin
          res_valid <= 1'b1;
          seg_count <= '0;
          ovf       <= 1'b0;
          nd        <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd_q.op)
      lisd_pkg::OP_LOAD_EA: begin
        ea  <= ev;
        dup <= 1'b0;
        acc <= '0;
      end
      lisd_pkg::OP_CMP_DUP: begin
        if (ev == ea) begin
          dup <= 1'b1;
        end
      end
      lisd_pkg::OP_CMP_RANK: begin
        if (flag_rd && (ev < ea)) begin
          acc <= acc + RB'(1);
        end
      end
      lisd_pkg::OP_SEL: begin
        if ((rk_r_rd == cmd_q.row[RB-1:0]) && (!prev_valid || (key < prev_key)) &&
            (!found || (key > best_key))) begin
          best_key <= key;
        end
      end
      lisd_pkg::OP_SEL_TAKE: begin
        prev_key <= best_key;
      end
      lisd_pkg::OP_LOAD_D: begin
        d <= cur_rd;
      end
      lisd_pkg::OP_SUF: begin
        run <= sr;
      end
      lisd_pkg::OP_RES: begin
        res_count <= BW'(cur_rd);
        res_ovf   <= ovf;
      end
      default: begin
      end
    endcase
  end

  // status to the sequencer
  assign stat.seg_n    = lisd_pkg::IDX_W'(seg_count);
  assign stat.m        = lisd_pkg::RANK_W'(nd) + lisd_pkg::RANK_W'(2);
  assign stat.found    = found;
  assign stat.sel_l    = lisd_pkg::RANK_W'(best_key[KW-1:SB]);
  assign stat.res_busy = res_valid;

endmodule
